// ----- src/ukl_pkg.sv -----
// Shared types and codes for the unique key list table.
package ukl_pkg;

    localparam int KEY_W = 32;
    localparam int POS_W = 4;

    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] entry_count;
    } rsp_t;

endpackage

// ----- src/ukl_if.sv -----
// Request and response channel interfaces.
interface ukl_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic signed [31:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface ukl_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] position;
    logic [3:0] entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

// ----- src/ukl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ukl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/ukl_ctrl.sv -----
// Sequencer: scans, appends and shifts keys held in the key RAM.
module ukl_ctrl #(
    parameter int CAPACITY = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [1:0]                    req_operation,
    input  logic [ukl_pkg::KEY_W-1:0]     req_key,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ukl_pkg::rsp_t                 res,
    output logic                          mem_wr_en,
    output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] mem_wr_addr,
    output logic [ukl_pkg::KEY_W-1:0]     mem_wr_data,
    output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] mem_rd_addr,
    input  logic [ukl_pkg::KEY_W-1:0]     mem_rd_data
);

    import ukl_pkg::*;

    localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t           state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    rsp_t             res_reg, res_next;

    logic accept;
    logic full;
    logic hit;
    logic more;

    assign accept = req_valid && (state_reg == S_IDLE);
    assign full   = count_reg >= CW'(CAPACITY);
    assign hit    = pend_reg && (mem_rd_data == key_reg);
    assign more   = rd_idx_reg < count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_operation == OP_INSERT && full) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit && op_reg == OP_REMOVE)
                begin
                    state_next = S_SHIFT;
                end
                else if (hit || !more)
                begin
                    state_next = S_FIN;
                end
            end
            S_SHIFT:
            begin
                if (!more)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        pend_next    = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        res_next     = res_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = cmp_idx_reg - AW'(1);
        mem_wr_data  = mem_rd_data;
        mem_rd_addr  = rd_idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next              = req_operation;
                    key_next             = req_key;
                    rd_idx_next          = '0;
                    res_next.status      = STAT_FULL;
                    res_next.position    = '0;
                    res_next.entry_count = POS_W'(count_reg);
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_next.position = POS_W'(CW'(cmp_idx_reg) + CW'(1));
                    res_next.status   = (op_reg == OP_INSERT) ? STAT_DUPLICATE : STAT_OK;
                    rd_idx_next       = CW'(cmp_idx_reg) + CW'(1);
                end
                else if (more)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next  = rd_idx_reg + CW'(1);
                end
                else if (op_reg == OP_INSERT)
                begin
                    mem_wr_en            = 1'b1;
                    mem_wr_addr          = count_reg[AW-1:0];
                    mem_wr_data          = key_reg;
                    count_next           = count_reg + CW'(1);
                    res_next.status      = STAT_OK;
                    res_next.position    = POS_W'(count_reg + CW'(1));
                    res_next.entry_count = POS_W'(count_reg + CW'(1));
                end
                else
                begin
                    res_next.status   = STAT_NOT_FOUND;
                    res_next.position = '0;
                end
            end
            S_SHIFT:
            begin
                mem_wr_en = pend_reg;
                if (more)
                begin
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next  = rd_idx_reg + CW'(1);
                end
                else
                begin
                    count_next           = count_reg - CW'(1);
                    res_next.entry_count = POS_W'(count_reg - CW'(1));
                end
            end
            S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res       = res_reg;

endmodule

// ----- src/unique_key_list_table_core.sv -----
// Unique key list table: top level with key RAM, sequencer and response register.
//
// Keeps up to CAPACITY distinct 32-bit keys in insertion order in a RAM with one
// read and one write port. A request (search, insert or remove) walks the stored
// keys one per cycle through the RAM read port until it finds the key or reaches
// the end; an insert into a full table skips the walk.
// A remove then moves each later key down one place, again one per cycle. One
// request is handled at a time; a response waits in an output register, and the
// next request is taken while it waits. The store is empty after reset; no
// clearing pass is needed.
module unique_key_list_table_core #(
    parameter int CAPACITY = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ukl_req_if.sink   req,
    ukl_rsp_if.source rsp
);

    import ukl_pkg::*;

    localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);

    logic             res_valid;
    logic             res_ready;
    rsp_t             res;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [KEY_W-1:0] mem_wr_data;
    logic [AW-1:0]    mem_rd_addr;
    logic [KEY_W-1:0] mem_rd_data;

    logic             out_valid_reg;
    rsp_t             out_reg;

    ukl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ukl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_operation (req.operation),
        .req_key       (req.key),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.position    = out_reg.position;
    assign rsp.entry_count = out_reg.entry_count;

endmodule
